[hw/rtl/spc_pkg.sv]
// Shared types, constants and helper functions of the servo position controller.
`timescale 1ns / 1ps

package spc_pkg;

  // Channel and field sizes.
  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned OFFS_W  = 24;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned BTN_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;

  // Serial parser constants.
  localparam logic [STEP_W-1:0] LAST_STEP  = 4'd11;
  localparam logic [POS_W-1:0]  ASCII_ZERO = 8'd48;

  // Configuration reset values.
  localparam logic [POS_W-1:0]  PERIOD_TOP_RST    = 8'd155;
  localparam logic [GAIN_W-1:0] GAIN_OUTER_RST    = 16'd2249;
  localparam logic [GAIN_W-1:0] GAIN_INNER_RST    = 16'd1863;
  localparam logic [OFFS_W-1:0] OFFSET_FIRST_RST  = 24'd104858;
  localparam logic [OFFS_W-1:0] OFFSET_SECOND_RST = 24'd452198;
  localparam logic [OFFS_W-1:0] OFFSET_THIRD_RST  = 24'd452198;
  localparam logic [OFFS_W-1:0] OFFSET_FOURTH_RST = 24'd648806;

  // Erased preset value.
  localparam logic [POS_W-1:0] PRESET_RST = 8'd255;

  // Kind of input transaction.
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ADC    = 2'd1,
    REQ_SERIAL = 2'd2,
    REQ_BUTTON = 2'd3
  } req_t;

  // Operating mode.
  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_RECALL = 2'd1,
    MODE_SERIAL = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_TOP    = 3'd0,
    CFG_GAIN_OUTER    = 3'd1,
    CFG_GAIN_INNER    = 3'd2,
    CFG_OFFSET_FIRST  = 3'd3,
    CFG_OFFSET_SECOND = 3'd4,
    CFG_OFFSET_THIRD  = 3'd5,
    CFG_OFFSET_FOURTH = 3'd6
  } cfg_idx_t;

  // Configuration register file as seen by the mapping unit.
  typedef struct packed {
    logic [POS_W-1:0]                period_top;
    logic [GAIN_W-1:0]               gain_outer;
    logic [GAIN_W-1:0]               gain_inner;
    logic [NUM_CH-1:0][OFFS_W-1:0]   offset;
  } cfg_t;

  // Channel addressed by a parser step; out-of-range steps act as step zero.
  function automatic logic [CH_W-1:0] step_chan(input logic [STEP_W-1:0] step);
    logic [CH_W-1:0] ch;
    case (step)
      4'd0, 4'd1, 4'd2:  ch = 2'd0;
      4'd3, 4'd4, 4'd5:  ch = 2'd1;
      4'd6, 4'd7, 4'd8:  ch = 2'd2;
      4'd9, 4'd10, 4'd11: ch = 2'd3;
      default:           ch = 2'd0;
    endcase
    return ch;
  endfunction

  // Digit position within a channel: hundreds, tens or units.
  function automatic logic [1:0] step_phase(input logic [STEP_W-1:0] step);
    logic [1:0] ph;
    case (step)
      4'd0, 4'd3, 4'd6, 4'd9:  ph = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: ph = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11: ph = 2'd2;
      default:                 ph = 2'd0;
    endcase
    return ph;
  endfunction

endpackage

[hw/rtl/spc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/spc_map.sv]
// Linear Q16 map from a raw value to a saturated channel position.
`timescale 1ns / 1ps

module spc_map (
  input  spc_pkg::cfg_t                  cfg,
  input  logic [spc_pkg::CH_W-1:0]       chan,
  input  logic [spc_pkg::POS_W-1:0]      raw,
  output logic [spc_pkg::POS_W-1:0]      pos
);

  localparam int unsigned PROD_W = spc_pkg::POS_W + spc_pkg::GAIN_W;
  localparam int unsigned SUM_W  = spc_pkg::OFFS_W + 1;

  logic [spc_pkg::GAIN_W-1:0] gain;
  logic [PROD_W-1:0]          prod;
  logic [SUM_W-1:0]           sum;
  logic [SUM_W-17:0]          whole;

  // Outer channels share one slope, inner channels the other.
  assign gain = (chan == 2'd0 || chan == 2'd3) ? cfg.gain_outer : cfg.gain_inner;

  // Multiply, add the offset, drop the fraction and clamp.
  assign prod  = {{spc_pkg::GAIN_W{1'b0}}, raw} * {{spc_pkg::POS_W{1'b0}}, gain};
  assign sum   = SUM_W'(prod) + {1'b0, cfg.offset[chan]};
  assign whole = sum[SUM_W-1:16];
  assign pos   = whole[SUM_W-17] ? {spc_pkg::POS_W{1'b1}} : whole[spc_pkg::POS_W-1:0];

endmodule

[hw/rtl/servo_position_controller_core.sv]
// Top level of the four-channel servo position controller.
`timescale 1ns / 1ps

// Takes one transaction per cycle unless the result stream stalls (tick,
// converter sample, serial character or button mask) and returns one result
// per transaction: the pulse levels seen before the transaction and the mode,
// indicator and four positions after it. A transaction passes through an
// input stage, where the raw-value RAM is read, and the output register. The
// raw values live in a four-entry RAM with a registered read port; a write
// from the executing transaction to the entry that the next one reads is
// forwarded, so transactions flow back to back. Each execute cycle holds one
// 8x16 multiply-add for the position map. Config writes are ready whenever
// the block is out of reset and must only be issued while the block is idle.
module servo_position_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // channel[1:0], sample[9:2], rx_byte[17:10], buttons[24:18]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pwm_levels[3:0], mode[5:4], indicator[13:6],
                                  // pos_first[21:14], pos_second[29:22],
                                  // pos_third[37:30], pos_fourth[45:38]
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int unsigned NCH   = spc_pkg::NUM_CH;
  localparam int unsigned PW    = spc_pkg::POS_W;
  localparam int unsigned SW    = spc_pkg::STEP_W;
  localparam int unsigned CW    = spc_pkg::CH_W;

  // Configuration registers.
  spc_pkg::cfg_t cfg_r;

  // Input stage.
  logic                     s1_valid_r;
  spc_pkg::req_t            s1_req_r;
  logic [CW-1:0]            s1_chan_r;
  logic [PW-1:0]            s1_sample_r;
  logic [PW-1:0]            s1_rx_r;
  logic [spc_pkg::BTN_W-1:0] s1_btn_r;
  logic                     s1_fwd_r;
  logic [PW-1:0]            s1_fwd_data_r;
  logic                     s1_rd_vld_r;

  // Controller state.
  spc_pkg::mode_t           mode_r, mode_nxt;
  logic [NCH-1:0][PW-1:0]   pos_r, pos_nxt;
  logic [NCH-1:0][PW-1:0]   preset_r, preset_nxt;
  logic [NCH-1:0]           raw_vld_r, raw_vld_nxt;
  logic [PW-1:0]            raw1_r, raw1_nxt;
  logic [SW-1:0]            step_r, step_nxt;
  logic [PW-1:0]            count_r, count_nxt;
  logic [PW-1:0]            ind_r, ind_nxt;

  // Output register.
  logic                     out_tvalid_r;
  logic [47:0]              out_tdata_r, out_tdata_nxt;

  // Pipeline control.
  logic accept_in;
  logic advance;
  logic s1_exec;

  // Raw-value RAM ports.
  logic          ram_wr_en;
  logic [CW-1:0] ram_wr_addr;
  logic [PW-1:0] ram_wr_data;
  logic [CW-1:0] ram_rd_addr;
  logic [PW-1:0] ram_rd_data;

  // Execute datapath.
  logic [SW-1:0]  cur_step;
  logic [CW-1:0]  ser_ch;
  logic [1:0]     ser_ph;
  logic [PW-1:0]  digit;
  logic [15:0]    digit_x100;
  logic [15:0]    digit_x10;
  logic [PW-1:0]  operand;
  logic [PW-1:0]  raw_new;
  logic [CW-1:0]  map_ch;
  logic [PW-1:0]  map_raw;
  logic [PW-1:0]  map_pos;
  logic [NCH-1:0] levels;
  spc_pkg::mode_t btn_mode;

  // Handshakes; nothing is taken while reset is asserted.
  assign advance   = !out_tvalid_r || out_tready;
  assign s1_exec   = s1_valid_r && advance;
  assign in_tready = rst_n && (!s1_valid_r || advance);
  assign accept_in = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_top <= spc_pkg::PERIOD_TOP_RST;
      cfg_r.gain_outer <= spc_pkg::GAIN_OUTER_RST;
      cfg_r.gain_inner <= spc_pkg::GAIN_INNER_RST;
      cfg_r.offset[0]  <= spc_pkg::OFFSET_FIRST_RST;
      cfg_r.offset[1]  <= spc_pkg::OFFSET_SECOND_RST;
      cfg_r.offset[2]  <= spc_pkg::OFFSET_THIRD_RST;
      cfg_r.offset[3]  <= spc_pkg::OFFSET_FOURTH_RST;
    end else if (cfg_valid) begin
      case (spc_pkg::cfg_idx_t'(cfg_index))
        spc_pkg::CFG_PERIOD_TOP:    cfg_r.period_top <= cfg_data[PW-1:0];
        spc_pkg::CFG_GAIN_OUTER:    cfg_r.gain_outer <= cfg_data[spc_pkg::GAIN_W-1:0];
        spc_pkg::CFG_GAIN_INNER:    cfg_r.gain_inner <= cfg_data[spc_pkg::GAIN_W-1:0];
        spc_pkg::CFG_OFFSET_FIRST:  cfg_r.offset[0]  <= cfg_data;
        spc_pkg::CFG_OFFSET_SECOND: cfg_r.offset[1]  <= cfg_data;
        spc_pkg::CFG_OFFSET_THIRD:  cfg_r.offset[2]  <= cfg_data;
        spc_pkg::CFG_OFFSET_FOURTH: cfg_r.offset[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Raw-value store.
  spc_ram #(
    .WIDTH(PW),
    .DEPTH(NCH)
  ) u_raw_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept_in),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The read is issued for the parser step the new transaction will see.
  assign ram_rd_addr = spc_pkg::step_chan(step_nxt);

  // Input stage registers, with forwarding of a same-cycle write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept_in) begin
      s1_valid_r <= 1'b1;
    end else if (s1_exec) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_req_r      <= spc_pkg::req_t'(in_tuser);
      s1_chan_r     <= in_tdata[1:0];
      s1_sample_r   <= in_tdata[9:2];
      s1_rx_r       <= in_tdata[17:10];
      s1_btn_r      <= in_tdata[24:18];
      s1_fwd_r      <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
      s1_fwd_data_r <= ram_wr_data;
      s1_rd_vld_r   <= raw_vld_r[ram_rd_addr];
    end
  end

  // Parser step decode and digit arithmetic.
  assign cur_step   = (step_r > spc_pkg::LAST_STEP) ? '0 : step_r;
  assign ser_ch     = spc_pkg::step_chan(cur_step);
  assign ser_ph     = spc_pkg::step_phase(cur_step);
  assign digit      = s1_rx_r - spc_pkg::ASCII_ZERO;
  assign digit_x100 = {8'd0, digit} * 16'd100;
  assign digit_x10  = {8'd0, digit} * 16'd10;
  assign operand    = s1_fwd_r ? s1_fwd_data_r : (s1_rd_vld_r ? ram_rd_data : '0);

  always_comb begin
    case (ser_ph)
      2'd0:    raw_new = digit_x100[PW-1:0];
      2'd1:    raw_new = operand + digit_x10[PW-1:0];
      default: raw_new = operand + digit;
    endcase
  end

  // One mapping unit serves converter samples and completed serial values.
  assign map_ch  = (s1_req_r == spc_pkg::REQ_ADC) ? s1_chan_r : ser_ch;
  assign map_raw = (s1_req_r == spc_pkg::REQ_ADC) ? s1_sample_r : raw_new;

  spc_map u_map (
    .cfg  (cfg_r),
    .chan (map_ch),
    .raw  (map_raw),
    .pos  (map_pos)
  );

  // Mode chosen by a button mask, highest mode bit winning.
  always_comb begin
    btn_mode = mode_r;
    if (s1_btn_r[0]) btn_mode = spc_pkg::MODE_MANUAL;
    if (s1_btn_r[1]) btn_mode = spc_pkg::MODE_RECALL;
    if (s1_btn_r[2]) btn_mode = spc_pkg::MODE_SERIAL;
  end

  // Execute: next state for the transaction in the input stage.
  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    preset_nxt  = preset_r;
    raw_vld_nxt = raw_vld_r;
    raw1_nxt    = raw1_r;
    step_nxt    = step_r;
    count_nxt   = count_r;
    ind_nxt     = ind_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = ser_ch;
    ram_wr_data = raw_new;
    if (s1_exec) begin
      case (s1_req_r)
        spc_pkg::REQ_TICK: begin
          count_nxt = (count_r >= cfg_r.period_top) ? '0 : count_r + 8'd1;
        end
        spc_pkg::REQ_ADC: begin
          if (mode_r == spc_pkg::MODE_MANUAL) begin
            ram_wr_en            = 1'b1;
            ram_wr_addr          = s1_chan_r;
            ram_wr_data          = s1_sample_r;
            raw_vld_nxt[s1_chan_r] = 1'b1;
            pos_nxt[s1_chan_r]   = map_pos;
            if (s1_chan_r == 2'd1) begin
              raw1_nxt = s1_sample_r;
            end
          end
        end
        spc_pkg::REQ_SERIAL: begin
          if (mode_r == spc_pkg::MODE_SERIAL) begin
            ram_wr_en           = 1'b1;
            raw_vld_nxt[ser_ch] = 1'b1;
            if (ser_ph == 2'd2) begin
              pos_nxt[ser_ch] = map_pos;
            end
            step_nxt = (cur_step == spc_pkg::LAST_STEP) ? '0 : cur_step + 4'd1;
            if (ser_ch == 2'd1) begin
              raw1_nxt = raw_new;
              ind_nxt  = raw_new;
            end else begin
              ind_nxt  = raw1_r;
            end
          end
        end
        default: begin
          mode_nxt = btn_mode;
          for (int k = 0; k < NCH; k++) begin
            if (s1_btn_r[3+k]) begin
              ind_nxt = PW'(1) << k;
              if (btn_mode == spc_pkg::MODE_RECALL) begin
                pos_nxt[k] = preset_r[k];
              end else begin
                preset_nxt[k] = pos_r[k];
              end
            end
          end
        end
      endcase
    end
  end

  // Pulse levels come from the counter and positions before the transaction.
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      levels[k] = count_r < pos_r[k];
    end
  end

  assign out_tdata_nxt = {2'b00, pos_nxt[3], pos_nxt[2], pos_nxt[1], pos_nxt[0],
                          ind_nxt, mode_nxt, levels};

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= spc_pkg::MODE_MANUAL;
      pos_r     <= '0;
      preset_r  <= {NCH{spc_pkg::PRESET_RST}};
      raw_vld_r <= '0;
      raw1_r    <= '0;
      step_r    <= '0;
      count_r   <= '0;
      ind_r     <= '0;
    end else begin
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      preset_r  <= preset_nxt;
      raw_vld_r <= raw_vld_nxt;
      raw1_r    <= raw1_nxt;
      step_r    <= step_nxt;
      count_r   <= count_nxt;
      ind_r     <= ind_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (advance) begin
      out_tvalid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_exec) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // The parser step never leaves its twelve-step range.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= spc_pkg::LAST_STEP)
    else $error("parser step out of range");

  // Only a serial transaction moves the parser step.
  a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_exec && s1_req_r != spc_pkg::REQ_SERIAL) |=> $stable(step_r))
    else $error("parser step moved without a serial transaction");

  // A save or recall leaves a one-hot indicator.
  a_ind_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_exec && s1_req_r == spc_pkg::REQ_BUTTON && s1_btn_r[6:3] != 4'd0)
      |=> $onehot(ind_r))
    else $error("indicator not one-hot after save or recall");
`endif

endmodule
